// ===== design/mbd_pkg.sv =====
`timescale 1ns / 1ps
package mbd_pkg;

  localparam int BOUNDARY_MAX = 58;
  localparam int WINDOW_DEPTH = 62;
  localparam int WIN_IDX_W    = $clog2(WINDOW_DEPTH);
  localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_DASH = 8'h2D;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_DATA  = 2'd2,
    FUNC_END   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_BYTE      = 3'd0,
    KIND_START     = 3'd1,
    KIND_END_BND   = 3'd2,
    KIND_END_NOBND = 3'd3,
    KIND_FAIL      = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] index;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] body_byte;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic       shift;
    logic       win_wr;
    logic       tok_wr;
    logic [7:0] wdata;
  } cell_ctl_t;

endpackage

// ===== design/mbd_cell.sv =====
`timescale 1ns / 1ps
module mbd_cell (
  input  logic              clk_i,
  input  mbd_pkg::cell_ctl_t ctl_i,
  input  logic [7:0]        right_i,
  input  logic [7:0]        pat_i,
  output logic [7:0]        win_o,
  output logic [7:0]        tok_o,
  output logic              match_o
);
  import mbd_pkg::*;

  logic [7:0] win_q, win_d;
  logic [7:0] tok_q;

  always_comb begin
    if (ctl_i.win_wr) begin
      win_d = ctl_i.wdata;
    end else if (ctl_i.shift) begin
      win_d = right_i;
    end else begin
      win_d = win_q;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (ctl_i.tok_wr) begin
      tok_q <= ctl_i.wdata;
    end
  end

  // compare on the value after this beat's push
  assign match_o = (win_d == pat_i);
  assign win_o   = win_q;
  assign tok_o   = tok_q;

endmodule

// ===== design/multipart_boundary_deframer.sv =====
`timescale 1ns / 1ps
// Multipart boundary deframer: pulls the first part's payload out of a multipart body.
// Input channel (in_valid_i / in_ready_o / in_beat_i): one command per beat:
//   start message, load one boundary byte, one stream byte, or end of content.
// Output channel (out_valid_o / out_ready_i / out_beat_o): body bytes and events;
//   last marks the final result beat caused by one input beat.
// cfg_we_i / cfg_wdata_i set the boundary token length; write it only while idle.
// Result beats are registered; ST_END and ST_FLUSH issue the deferred ones.
// Throughput: one input beat per cycle while the receiver keeps taking results and
//   no end or flush is pending; the output register refills in the cycle it empties.
// A body byte that completes the end marker while pushing out an older byte yields
//   two result beats (byte, then end at boundary).
// End of content in the body flushes the n held bytes through cell 0 of the
//   shift window, then ends without boundary, with input held off meanwhile.
// When the receiver stalls, the output register holds its beat and in_ready_o drops.
// Reset clears the phase to preamble, the window fill to empty and the token length
//   to 1; boundary bytes are undefined until loaded.
module multipart_boundary_deframer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mbd_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mbd_pkg::out_beat_t out_beat_o
);
  import mbd_pkg::*;

  typedef enum logic [4:0] {
    PH_PRE    = 5'b00001,
    PH_SKIP   = 5'b00010,
    PH_HEADER = 5'b00100,
    PH_BODY   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_END   = 3'b010,
    ST_FLUSH = 3'b100
  } st_e;

  phase_e phase_q, phase_d;
  st_e    st_q, st_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [1:0]        skip_q, skip_d, skip_inc;
  logic [5:0]        blen_q, tok_len;

  logic              out_valid_q;
  out_beat_t         out_q;
  logic              out_free, in_acc;

  logic [FILL_W-1:0]    cap, fc, fill_post;
  logic                 full, match_all, match_ok;
  logic [WIN_IDX_W-1:0] widx;
  logic                 push_en, load_en, win_shift;

  logic       emit, emit_last;
  kind_e      emit_kind;
  logic [7:0] emit_byte;

  logic [7:0]              win      [WINDOW_DEPTH];
  logic [7:0]              tok      [WINDOW_DEPTH];
  logic [7:0]              pat_pre  [WINDOW_DEPTH];
  logic [7:0]              pat_body [WINDOW_DEPTH];
  logic [7:0]              cell_pat [WINDOW_DEPTH];
  logic [7:0]              right    [WINDOW_DEPTH];
  cell_ctl_t               cell_ctl [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] cell_match, in_cap, tok_wr;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (st_q == ST_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    if (blen_q == 6'd0) begin
      tok_len = 6'd1;
    end else if (blen_q > 6'(BOUNDARY_MAX)) begin
      tok_len = 6'(BOUNDARY_MAX);
    end else if (blen_q > 6'(WINDOW_DEPTH - 4)) begin
      tok_len = 6'(WINDOW_DEPTH - 4);
    end else begin
      tok_len = blen_q;
    end
  end

  always_comb begin
    case (phase_q)
      PH_PRE:    cap = FILL_W'(tok_len) + FILL_W'(2);
      PH_HEADER: cap = FILL_W'(4);
      default:   cap = FILL_W'(tok_len) + FILL_W'(4);
    endcase
  end

  assign fc        = (fill_q > cap) ? cap : fill_q;
  assign full      = (fc == cap);
  assign fill_post = full ? cap : fc + FILL_W'(1);
  assign widx      = full ? WIN_IDX_W'(cap - FILL_W'(1)) : WIN_IDX_W'(fc);
  assign match_all = &(cell_match | ~in_cap);
  assign match_ok  = match_all && (fill_post == cap);
  assign skip_inc  = skip_q + 2'd1;

  // window push and shift strobes
  assign push_en   = in_acc && (in_beat_i.func == FUNC_DATA) &&
                     (phase_q inside {PH_PRE, PH_HEADER, PH_BODY});
  assign win_shift = (push_en && full) ||
                     ((st_q == ST_FLUSH) && out_free && (fill_q != '0));

  // window cells
  for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
    localparam logic [WIN_IDX_W-1:0] IDX     = WIN_IDX_W'(g);
    localparam logic [5:0]           TOK_IDX = 6'(g);
    localparam logic [FILL_W-1:0]    POS     = FILL_W'(g);

    if (g < 2) begin : g_pre_dash
      assign pat_pre[g] = CHAR_DASH;
    end else if (g - 2 < BOUNDARY_MAX) begin : g_pre_tok
      assign pat_pre[g] = tok[g-2];
    end else begin : g_pre_none
      assign pat_pre[g] = 8'h00;
    end

    if (g == 0) begin : g_body_cr
      assign pat_body[g] = CHAR_CR;
    end else if (g == 1) begin : g_body_lf
      assign pat_body[g] = CHAR_LF;
    end else if (g < 4) begin : g_body_dash
      assign pat_body[g] = CHAR_DASH;
    end else if (g - 4 < BOUNDARY_MAX) begin : g_body_tok
      assign pat_body[g] = tok[g-4];
    end else begin : g_body_none
      assign pat_body[g] = 8'h00;
    end

    always_comb begin
      case (phase_q)
        PH_PRE:    cell_pat[g] = pat_pre[g];
        PH_HEADER: cell_pat[g] = (g % 2 == 1) ? CHAR_LF : CHAR_CR;
        default:   cell_pat[g] = pat_body[g];
      endcase
    end

    if (g < BOUNDARY_MAX) begin : g_tok_wr
      assign tok_wr[g] = load_en && (in_beat_i.index == TOK_IDX);
    end else begin : g_tok_none
      assign tok_wr[g] = 1'b0;
    end

    if (g == WINDOW_DEPTH - 1) begin : g_right_end
      assign right[g] = 8'h00;
    end else begin : g_right
      assign right[g] = win[g+1];
    end

    assign in_cap[g] = (POS < cap);
    assign cell_ctl[g] = '{
      shift:  win_shift,
      win_wr: push_en && (widx == IDX),
      tok_wr: tok_wr[g],
      wdata:  in_beat_i.data_byte
    };

    mbd_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[g]),
      .right_i (right[g]),
      .pat_i   (cell_pat[g]),
      .win_o   (win[g]),
      .tok_o   (tok[g]),
      .match_o (cell_match[g])
    );
  end

  always_comb begin
    phase_d   = phase_q;
    st_d      = st_q;
    fill_d    = fill_q;
    skip_d    = skip_q;
    load_en   = 1'b0;
    emit      = 1'b0;
    emit_kind = KIND_BYTE;
    emit_byte = 8'h00;
    emit_last = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_beat_i.func)
            FUNC_START: begin
              phase_d = PH_PRE;
              skip_d  = 2'd0;
              fill_d  = '0;
            end
            FUNC_LOAD: begin
              load_en = 1'b1;
            end
            FUNC_DATA: begin
              unique case (phase_q)
                PH_PRE: begin
                  fill_d = fill_post;
                  if (match_ok) begin
                    phase_d = PH_SKIP;
                    skip_d  = 2'd0;
                    fill_d  = '0;
                  end
                end
                PH_SKIP: begin
                  if (skip_inc >= 2'd2) begin
                    phase_d = PH_HEADER;
                    skip_d  = 2'd0;
                    fill_d  = '0;
                  end else begin
                    skip_d = skip_inc;
                  end
                end
                PH_HEADER: begin
                  fill_d = fill_post;
                  if (match_ok) begin
                    phase_d   = PH_BODY;
                    fill_d    = '0;
                    emit      = 1'b1;
                    emit_kind = KIND_START;
                    emit_last = 1'b1;
                  end
                end
                PH_BODY: begin
                  fill_d = fill_post;
                  if (full) begin
                    emit      = 1'b1;
                    emit_kind = KIND_BYTE;
                    emit_byte = win[0];
                    emit_last = !match_ok;
                  end
                  if (match_ok) begin
                    phase_d = PH_DONE;
                    fill_d  = '0;
                    if (full) begin
                      st_d = ST_END;
                    end else begin
                      emit      = 1'b1;
                      emit_kind = KIND_END_BND;
                      emit_last = 1'b1;
                    end
                  end
                end
                default: begin
                end
              endcase
            end
            FUNC_END: begin
              if (phase_q == PH_BODY) begin
                st_d = ST_FLUSH;
              end else if (phase_q != PH_DONE) begin
                phase_d   = PH_DONE;
                fill_d    = '0;
                emit      = 1'b1;
                emit_kind = KIND_FAIL;
                emit_last = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_END: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = KIND_END_BND;
          emit_last = 1'b1;
          st_d      = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit = 1'b1;
          if (fill_q != '0) begin
            emit_kind = KIND_BYTE;
            emit_byte = win[0];
            fill_d    = fill_q - FILL_W'(1);
          end else begin
            emit_kind = KIND_END_NOBND;
            emit_last = 1'b1;
            phase_d   = PH_DONE;
            st_d      = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PRE;
      st_q        <= ST_IDLE;
      fill_q      <= '0;
      skip_q      <= 2'd0;
      blen_q      <= 6'd1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      st_q    <= st_d;
      fill_q  <= fill_d;
      skip_q  <= skip_d;
      if (cfg_we_i) begin
        blen_q <= cfg_wdata_i;
      end
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit) begin
      out_q <= '{
        kind:      emit_kind,
        body_byte: (emit_kind == KIND_BYTE) ? emit_byte : 8'h00,
        last:      emit_last
      };
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

`ifndef SYNTHESIS
  a_flush_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_FLUSH |-> phase_q == PH_BODY)
    else $error("flush outside body phase");

  a_end_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_END |-> phase_q == PH_DONE && fill_q == '0)
    else $error("pending end at boundary with live window");

  a_event_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.kind != KIND_BYTE |-> out_beat_o.last)
    else $error("event beat without last");

  a_skip_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SKIP |-> fill_q == '0)
    else $error("window not empty while skipping");
`endif

endmodule

// ===== verif/multipart_boundary_deframer_checker.sv =====
`timescale 1ns / 1ps
module multipart_boundary_deframer_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  mbd_pkg::in_beat_t  in_beat_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  mbd_pkg::out_beat_t out_beat_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import mbd_pkg::*;

  typedef enum logic [2:0] {
    PH_PREAMBLE,
    PH_SKIP,
    PH_HEADER,
    PH_BODY,
    PH_DONE
  } phase_e;

  localparam int PAT_LEAD   = 0;
  localparam int PAT_HEADER = 1;
  localparam int PAT_MARKER = 2;
  localparam int REPORT_MAX = 10;

  logic [7:0] token [BOUNDARY_MAX];
  logic [7:0] win [WINDOW_DEPTH];
  phase_e     phase = PH_PREAMBLE;
  int         skip_cnt = 0;
  int         fill = 0;
  logic [5:0] token_len_reg = 6'd1;
  out_beat_t  deframed_q [$];
  int         mismatches = 0;
  int         pending = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending;

  function automatic int token_len();
    int n;
    n = int'(token_len_reg);
    if (n == 0) n = 1;
    if (n > BOUNDARY_MAX) n = BOUNDARY_MAX;
    if (n + 4 > WINDOW_DEPTH) n = WINDOW_DEPTH - 4;
    return n;
  endfunction

  function automatic logic [7:0] pattern_at(int mode, int i);
    int j;
    j = i;
    if (mode == PAT_HEADER) return (i % 2) ? CHAR_LF : CHAR_CR;
    if (mode == PAT_MARKER) begin
      if (i == 0) return CHAR_CR;
      if (i == 1) return CHAR_LF;
      j = i - 2;
    end
    if (j < 2) return CHAR_DASH;
    return token[j - 2];
  endfunction

  function automatic bit tail_is(int mode, int n);
    if (n == 0 || fill < n) return 1'b0;
    for (int k = 0; k < n; k++) begin
      if (win[fill - n + k] !== pattern_at(mode, k)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_win();
    foreach (win[k]) win[k] = 8'h00;
    fill = 0;
  endfunction

  // shift a byte in; reports the byte that falls out of a full window
  function automatic bit push_win(input logic [7:0] b, input int cap,
                                  output logic [7:0] dropped);
    bit shifted;
    shifted = 1'b0;
    dropped = 8'h00;
    if (fill > cap) fill = cap;
    if (fill == cap) begin
      dropped = win[0];
      for (int k = 0; k < cap - 1; k++) win[k] = win[k + 1];
      fill = cap - 1;
      shifted = 1'b1;
    end
    win[fill] = b;
    fill++;
    return shifted;
  endfunction

  function automatic out_beat_t make_beat(kind_e k, logic [7:0] v);
    out_beat_t r;
    r.kind      = k;
    r.body_byte = (k == KIND_BYTE) ? v : 8'h00;
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic void deframe(in_beat_t b);
    out_beat_t  res [$];
    logic [7:0] gone;
    int         n;
    n = token_len();
    case (b.func)
      FUNC_START: begin
        phase    = PH_PREAMBLE;
        skip_cnt = 0;
        clear_win();
      end
      FUNC_LOAD: begin
        if (b.index < BOUNDARY_MAX) token[b.index] = b.data_byte;
      end
      FUNC_DATA: begin
        case (phase)
          PH_PREAMBLE: begin
            void'(push_win(b.data_byte, n + 2, gone));
            if (tail_is(PAT_LEAD, n + 2)) begin
              phase    = PH_SKIP;
              skip_cnt = 0;
              clear_win();
            end
          end
          PH_SKIP: begin
            skip_cnt = (skip_cnt + 1) % 4;
            if (skip_cnt >= 2) begin
              phase    = PH_HEADER;
              skip_cnt = 0;
              clear_win();
            end
          end
          PH_HEADER: begin
            void'(push_win(b.data_byte, 4, gone));
            if (tail_is(PAT_HEADER, 4)) begin
              phase = PH_BODY;
              clear_win();
              res.push_back(make_beat(KIND_START, 8'h00));
            end
          end
          PH_BODY: begin
            if (push_win(b.data_byte, n + 4, gone)) res.push_back(make_beat(KIND_BYTE, gone));
            if (tail_is(PAT_MARKER, n + 4)) begin
              for (int k = 0; k + n + 4 < fill; k++)
                res.push_back(make_beat(KIND_BYTE, win[k]));
              clear_win();
              phase = PH_DONE;
              res.push_back(make_beat(KIND_END_BND, 8'h00));
            end
          end
          default: ;
        endcase
      end
      FUNC_END: begin
        if (phase == PH_BODY) begin
          for (int k = 0; k < fill; k++) res.push_back(make_beat(KIND_BYTE, win[k]));
          clear_win();
          phase = PH_DONE;
          res.push_back(make_beat(KIND_END_NOBND, 8'h00));
        end else if (phase != PH_DONE) begin
          clear_win();
          phase = PH_DONE;
          res.push_back(make_beat(KIND_FAIL, 8'h00));
        end
      end
      default: ;
    endcase
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[k]) deframed_q.push_back(res[k]);
  endfunction

  function automatic void check_beat(out_beat_t got);
    out_beat_t want;
    if (deframed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("unexpected result beat: kind %0d byte %02h last %0b",
                 got.kind, got.body_byte, got.last);
      return;
    end
    want = deframed_q.pop_front();
    if (got.kind !== want.kind || got.body_byte !== want.body_byte ||
        got.last !== want.last) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display({"result mismatch: expected kind %0d byte %02h last %0b, ",
                  "got kind %0d byte %02h last %0b"},
                 want.kind, want.body_byte, want.last,
                 got.kind, got.body_byte, got.last);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase         = PH_PREAMBLE;
      skip_cnt      = 0;
      token_len_reg = 6'd1;
      clear_win();
      deframed_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_beat(out_beat_i);
      if (in_valid_i && in_ready_i) deframe(in_beat_i);
      if (cfg_we_i) token_len_reg = cfg_wdata_i;
    end
    pending = deframed_q.size();
  end

endmodule

// ===== verif/multipart_boundary_deframer_tb.sv =====
`timescale 1ns / 1ps
module multipart_boundary_deframer_tb;
  import mbd_pkg::*;

  localparam int SETTLE      = 80;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 420;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_CADENCE
  } rx_mode_e;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic [5:0] cfg_wdata = 6'd0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_beat;
  int        fail_count;
  int        pending;

  logic [7:0] tok_copy [BOUNDARY_MAX];
  int         tlen = 1;
  int         items = 0;
  int         burst_left = 0;
  int         hold_reqs = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multipart_boundary_deframer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_beat_o  (out_beat)
  );

  multipart_boundary_deframer_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_beat_i    (in_beat),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_beat_i   (out_beat),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  task automatic send(func_e f, logic [5:0] idx, logic [7:0] v);
    in_beat_t b;
    bit       taken;
    b.func      = f;
    b.index     = idx;
    b.data_byte = v;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      in_beat  <= in_beat_t'(16'($urandom));
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_beat  <= b;
    if (f == FUNC_LOAD && idx < BOUNDARY_MAX) tok_copy[idx] = v;
    items++;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_data(logic [7:0] v);
    send(FUNC_DATA, 6'($urandom), v);
  endtask

  task automatic send_end();
    send(FUNC_END, 6'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return CHAR_CR;
      1: return CHAR_LF;
      2: return CHAR_DASH;
      3: return tok_copy[$urandom_range(0, tlen - 1)];
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_lead();
    send_data(CHAR_DASH);
    send_data(CHAR_DASH);
    for (int k = 0; k < tlen; k++) send_data(tok_copy[k]);
  endtask

  task automatic send_hdr_end();
    send_data(CHAR_CR);
    send_data(CHAR_LF);
    send_data(CHAR_CR);
    send_data(CHAR_LF);
  endtask

  task automatic send_marker();
    send_data(CHAR_CR);
    send_data(CHAR_LF);
    send_lead();
  endtask

  task automatic open_body();
    send(FUNC_START, 6'($urandom), 8'($urandom));
    send_lead();
    send_data(8'($urandom));
    send_data(8'($urandom));
    send_hdr_end();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_len(logic [5:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tlen = (v == 6'd0) ? 1 : (v > BOUNDARY_MAX) ? BOUNDARY_MAX : int'(v);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) send(func_e'($urandom_range(0, 3)), 6'($urandom), 8'($urandom));
  endtask

  task automatic run_message();
    int ending;
    int cut;
    ending = $urandom_range(0, 19);
    send(FUNC_START, 6'($urandom), 8'($urandom));
    repeat ($urandom_range(0, 3)) send_data(pick_byte());
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(0, tlen - 1);
      send_data(CHAR_DASH);
      send_data(CHAR_DASH);
      for (int k = 0; k < cut; k++) send_data(tok_copy[k]);
      send_data(8'($urandom));
    end
    if (ending == 0) begin
      send_end();
      return;
    end
    send_lead();
    send_data(8'($urandom));
    if (ending == 1) begin
      send_end();
      return;
    end
    send_data(8'($urandom));
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 2))
        0: send_data(CHAR_CR);
        1: send_data(CHAR_LF);
        default: send_data(8'($urandom));
      endcase
    end
    if (ending == 2) begin
      send_end();
      return;
    end
    send_hdr_end();
    if ($urandom_range(0, 9) == 0) send(FUNC_LOAD, 6'($urandom_range(0, 63)), 8'($urandom));
    repeat ($urandom_range(0, 14)) send_data(pick_byte());
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(0, tlen - 1);
      send_data(CHAR_CR);
      send_data(CHAR_LF);
      send_data(CHAR_DASH);
      send_data(CHAR_DASH);
      for (int k = 0; k < cut; k++) send_data(tok_copy[k]);
      send_data(pick_byte());
    end
    if (ending < 7) begin
      send_end();
    end else if (ending >= 9) begin
      send_marker();
      repeat ($urandom_range(0, 2)) send_data(8'($urandom));
      if ($urandom_range(0, 1) == 1) send_end();
    end
  endtask

  initial begin : receiver
    rx_mode_e mode;
    int       span;
    int       holds_done;
    int       tick;
    holds_done = 0;
    tick = 0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (hold_reqs != holds_done) begin
          holds_done++;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ((tick % 7) < 4);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [5:0] len_pick;
    bit         held;
    bit         paused;
    held = 1'b0;
    paused = 1'b0;
    foreach (tok_copy[k]) tok_copy[k] = 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // boundary store is undefined out of reset, fill every entry first
    for (int k = 0; k < BOUNDARY_MAX; k++) send(FUNC_LOAD, 6'(k), 8'($urandom));

    // loads past the store are dropped
    send(FUNC_LOAD, 6'(BOUNDARY_MAX), 8'hFF);
    send(FUNC_LOAD, 6'h3F, 8'h00);
    // end of content before any body, then again once done, then a stray byte
    send_end();
    send_end();
    send_data(8'h5A);
    // short part closed at the boundary, token length from reset
    open_body();
    send_data(8'h00);
    send_data(8'hFF);
    send_marker();

    // zero length acts as one
    set_len(6'd0);
    while (items < 150) begin
      if (!held && items > 100) begin
        hold_reqs++;
        held = 1'b1;
      end
      if (!paused && items > 125) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) send_noise();
      run_message();
    end

    // out of range length saturates, full window flushed at end of content
    set_len(6'd63);
    open_body();
    repeat (WINDOW_DEPTH) send_data(8'($urandom));
    send_end();

    // longest legal token, closed at the boundary
    set_len(6'd58);
    open_body();
    repeat (3) send_data(pick_byte());
    send_marker();
    send_end();

    while (items < ITEM_TARGET) begin
      len_pick = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(9, 24)) :
                                               6'($urandom_range(1, 8));
      set_len(len_pick);
      repeat ($urandom_range(3, 6)) begin
        if (items >= ITEM_TARGET) break;
        if ($urandom_range(0, 7) == 0) send_noise();
        run_message();
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("[multipart_boundary_deframer] OK");
    end else begin
      $display("[multipart_boundary_deframer] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2500000;
    $display("[multipart_boundary_deframer] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mbd_pkg.sv
design/mbd_cell.sv
design/multipart_boundary_deframer.sv
verif/multipart_boundary_deframer_checker.sv
verif/multipart_boundary_deframer_tb.sv
